// ===== rtl/glos_pkg.sv =====
package glos_pkg;

    localparam int COORD_W        = 6;
    localparam int GRID_SIDE_DFLT = 64;
    // holds the Bresenham error term: it stays within -63 .. 189
    localparam int ERR_W          = 10;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef enum logic [1:0] {
        SEL_CUR,
        SEL_MINOR,
        SEL_MAJOR
    } t_rd_sel;

    typedef struct packed {
        logic    clr_en;
        logic    wr_en;
        logic    load;
        t_rd_sel rd_sel;
        logic    adv_a;
        logic    inc_b;
        logic    upd_err;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic blocked;
        logic step_minor;
        logic a_last;
        logic a_done;
    } t_sts;

endpackage

// ===== rtl/glos_req_if.sv =====
interface glos_req_if import glos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] row_b;
    logic [COORD_W-1:0] col_b;
    logic               blocked_bit;

    modport source (
        output valid, action, row_a, col_a, row_b, col_b, blocked_bit,
        input  ready
    );
    modport sink (
        input  valid, action, row_a, col_a, row_b, col_b, blocked_bit,
        output ready
    );
endinterface

// ===== rtl/glos_rsp_if.sv =====
interface glos_rsp_if import glos_pkg::*; ();
    logic valid;
    logic ready;
    logic line_clear;

    modport source (
        output valid, line_clear,
        input  ready
    );
    modport sink (
        input  valid, line_clear,
        output ready
    );
endinterface

// ===== rtl/glos_ram.sv =====
module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/glos_dp.sv =====
module glos_dp import glos_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [COORD_W-1:0] i_row_a,
    input  logic [COORD_W-1:0] i_col_a,
    input  logic [COORD_W-1:0] i_row_b,
    input  logic [COORD_W-1:0] i_col_b,
    input  logic               i_blocked_bit,
    output t_sts               o_sts
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(GRID_SIDE + 1);
    localparam int IDX_W  = (ADDR_W > COORD_W + SIDE_W + 1) ? ADDR_W
                                                             : COORD_W + SIDE_W + 1;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col
    );
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(row) * IDX_W'(GRID_SIDE) + IDX_W'(col);
        return idx[ADDR_W-1:0];
    endfunction

    function automatic logic cell_outside(
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col
    );
        return (32'(row) >= GRID_SIDE) || (32'(col) >= GRID_SIDE);
    endfunction

    // walk registers: major coordinate a, minor coordinate b
    logic [COORD_W-1:0]      r_a, r_a2, r_b, r_db, r_ada;
    logic                    r_neg, r_swp, r_oob;
    logic signed [ERR_W-1:0] r_err;
    logic [ADDR_W-1:0]       r_clr_addr;

    // setup terms from the request
    logic [COORD_W-1:0] s_abs_r, s_abs_c, s_maj1, s_maj2, s_min1, s_min2;
    logic [COORD_W-1:0] s_a1, s_a2, s_b1, s_b2;
    logic               s_swp, s_flip, s_neg;

    logic [COORD_W-1:0]      a_nxt, cand_a, cand_b, cand_row, cand_col;
    logic signed [ERR_W-1:0] err_add, err_sub, ada_s;
    logic                    rd_data, ram_we, ram_wdata;
    logic [ADDR_W-1:0]       ram_waddr;

    always_comb begin
        s_abs_r = (i_row_a >= i_row_b) ? i_row_a - i_row_b : i_row_b - i_row_a;
        s_abs_c = (i_col_a >= i_col_b) ? i_col_a - i_col_b : i_col_b - i_col_a;
        // rows stay major on a tie
        s_swp   = s_abs_r < s_abs_c;
        s_maj1  = s_swp ? i_col_a : i_row_a;
        s_maj2  = s_swp ? i_col_b : i_row_b;
        s_min1  = s_swp ? i_row_a : i_col_a;
        s_min2  = s_swp ? i_row_b : i_col_b;
        // start from the endpoint with the smaller minor coordinate
        s_flip  = s_min1 > s_min2;
        s_a1    = s_flip ? s_maj2 : s_maj1;
        s_a2    = s_flip ? s_maj1 : s_maj2;
        s_b1    = s_flip ? s_min2 : s_min1;
        s_b2    = s_flip ? s_min1 : s_min2;
        s_neg   = s_a2 < s_a1;
    end

    always_comb begin
        a_nxt   = r_neg ? r_a - COORD_W'(1) : r_a + COORD_W'(1);
        ada_s   = signed'(ERR_W'(r_ada));
        err_add = r_err + signed'(ERR_W'(r_db) << 1);
        err_sub = err_add - (ada_s <<< 1);

        case (i_cmd.rd_sel)
            SEL_MINOR: begin
                cand_a = r_a;
                cand_b = r_b + COORD_W'(1);
            end
            SEL_MAJOR: begin
                cand_a = a_nxt;
                cand_b = r_b;
            end
            default: begin
                cand_a = r_a;
                cand_b = r_b;
            end
        endcase
        cand_row = r_swp ? cand_b : cand_a;
        cand_col = r_swp ? cand_a : cand_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_oob <= cell_outside(cand_row, cand_col);
        if (i_cmd.load) begin
            r_a   <= s_a1;
            r_a2  <= s_a2;
            r_b   <= s_b1;
            r_db  <= s_b2 - s_b1;
            r_neg <= s_neg;
            r_ada <= s_neg ? s_a1 - s_a2 : s_a2 - s_a1;
            r_swp <= s_swp;
            r_err <= -signed'(ERR_W'(s_b2 - s_b1));
        end else begin
            if (i_cmd.adv_a) begin
                r_a <= a_nxt;
            end
            if (i_cmd.inc_b) begin
                r_b <= r_b + COORD_W'(1);
            end
            if (i_cmd.upd_err) begin
                r_err <= (err_add > ada_s) ? err_sub : err_add;
            end
        end
    end

    // clear pass owns the write port; a request write outside the grid is dropped
    assign ram_we    = i_cmd.clr_en
                     || (i_cmd.wr_en && !cell_outside(i_row_a, i_col_a));
    assign ram_waddr = i_cmd.clr_en ? r_clr_addr : cell_addr(i_row_a, i_col_a);
    assign ram_wdata = i_cmd.clr_en ? 1'b0 : i_blocked_bit;

    glos_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cell_addr(cand_row, cand_col)),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_sts.clr_last   = r_clr_addr == ADDR_W'(DEPTH - 1);
        o_sts.blocked    = r_oob || rd_data;
        o_sts.step_minor = err_add > ada_s;
        o_sts.a_last     = a_nxt == r_a2;
        o_sts.a_done     = r_a == r_a2;
    end

endmodule

// ===== rtl/glos_ctrl.sv =====
module glos_ctrl import glos_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_action,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic o_line_clear,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_MAJOR,
        ST_MINOR,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_res, n_res;
    logic   r_out_valid, n_out_valid;
    logic   r_line_clear, n_line_clear;
    t_cmd   cmd;

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_line_clear = r_line_clear;
        cmd          = '0;
        cmd.rd_sel   = SEL_CUR;

        case (r_state)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_CHECK) begin
                        cmd.load = 1'b1;
                        n_state  = ST_START;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_START: begin
                // equal endpoints visit nothing
                if (i_sts.a_done) begin
                    n_res   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    cmd.rd_sel = SEL_CUR;
                    n_state    = ST_MAJOR;
                end
            end
            ST_MAJOR: begin
                if (i_sts.blocked) begin
                    n_res   = 1'b0;
                    n_state = ST_DONE;
                end else if (i_sts.step_minor) begin
                    cmd.upd_err = 1'b1;
                    cmd.inc_b   = 1'b1;
                    cmd.rd_sel  = SEL_MINOR;
                    n_state     = ST_MINOR;
                end else begin
                    cmd.upd_err = 1'b1;
                    cmd.adv_a   = 1'b1;
                    if (i_sts.a_last) begin
                        n_res   = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        cmd.rd_sel = SEL_MAJOR;
                    end
                end
            end
            ST_MINOR: begin
                if (i_sts.blocked) begin
                    n_res   = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    cmd.adv_a = 1'b1;
                    if (i_sts.a_last) begin
                        n_res   = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        cmd.rd_sel = SEL_MAJOR;
                        n_state    = ST_MAJOR;
                    end
                end
            end
            ST_DONE: begin
                // hold the answer until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_line_clear = r_res;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_res        <= n_res;
        r_line_clear <= n_line_clear;
    end

    assign o_in_ready   = r_state == ST_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_line_clear = r_line_clear;
    assign o_cmd        = cmd;

endmodule

// ===== rtl/grid_line_of_sight_check.sv =====
// Channel   Dir  Modport  Payload
// i_req     in   sink     action, row_a, col_a, row_b, col_b, blocked_bit
// o_rsp     out  source   line_clear (one per check request, none per write)
//
// A check request visits one cell per cycle; the grid RAM has a single read port.
// After reset a clearing pass zeroes the grid, with i_req.ready low. A stalled
// response waits in the output register; the next write request is still taken
// while it waits.
module grid_line_of_sight_check import glos_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DFLT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    glos_req_if.sink   i_req,
    glos_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    glos_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .o_in_ready   (i_req.ready),
        .i_action     (i_req.action),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_line_clear (o_rsp.line_clear),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    glos_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_row_a       (i_req.row_a),
        .i_col_a       (i_req.col_a),
        .i_row_b       (i_req.row_b),
        .i_col_b       (i_req.col_b),
        .i_blocked_bit (i_req.blocked_bit),
        .o_sts         (sts)
    );

endmodule

// ===== bench/glos_checker.sv =====
module glos_checker import glos_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DFLT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    glos_req_if  i_req,
    glos_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    bit [GRID_SIDE*GRID_SIDE-1:0] obstacle_map;
    logic                         clear_expected [$];
    int                           fail_total = 0;

    function automatic void record_expected(logic val);
        clear_expected.insert(clear_expected.size(), val);
    endfunction

    function automatic bit cell_is_blocked(int row, int col);
        // anything off the grid counts as an obstacle
        if (row < 0 || col < 0 || row >= GRID_SIDE || col >= GRID_SIDE) begin
            return 1'b1;
        end
        return obstacle_map[row * GRID_SIDE + col];
    endfunction

    function automatic bit line_is_clear(int r1, int c1, int r2, int c2);
        int maj1, min1, maj2, min2;
        int d_maj, d_min, tmp, step, span, minor, err, major;
        bit swapped;
        d_maj = r2 - r1;
        d_min = c2 - c1;
        // walk along the axis with the larger absolute delta, rows on a tie
        swapped = ((d_maj < 0) ? -d_maj : d_maj) < ((d_min < 0) ? -d_min : d_min);
        maj1 = swapped ? c1 : r1;
        min1 = swapped ? r1 : c1;
        maj2 = swapped ? c2 : r2;
        min2 = swapped ? r2 : c2;
        d_maj = maj2 - maj1;
        d_min = min2 - min1;
        // start from the endpoint with the smaller minor coordinate
        if (min1 > min2) begin
            tmp   = maj1;
            maj1  = maj2;
            maj2  = tmp;
            tmp   = min1;
            min1  = min2;
            min2  = tmp;
            d_maj = -d_maj;
            d_min = -d_min;
        end
        step  = (d_maj < 0) ? -1 : 1;
        span  = (d_maj < 0) ? -d_maj : d_maj;
        minor = min1;
        err   = -d_min;
        for (major = maj1; major != maj2; major += step) begin
            if (swapped ? cell_is_blocked(minor, major) : cell_is_blocked(major, minor)) begin
                return 1'b0;
            end
            err += 2 * d_min;
            if (err > span) begin
                err -= 2 * span;
                minor++;
                // the cell reached by the minor step is visited too
                if (swapped ? cell_is_blocked(minor, major)
                            : cell_is_blocked(major, minor)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            obstacle_map = '0;
            clear_expected.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (clear_expected.size() == 0) begin
                    $error("line_clear: no check request waiting, got %0b", i_rsp.line_clear);
                    fail_total++;
                end else begin
                    want = clear_expected.pop_front();
                    if (i_rsp.line_clear !== want) begin
                        $error("line_clear: expected %0b, got %0b", want, i_rsp.line_clear);
                        fail_total++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == ACT_WRITE) begin
                    if (int'(i_req.row_a) < GRID_SIDE && int'(i_req.col_a) < GRID_SIDE) begin
                        obstacle_map[int'(i_req.row_a) * GRID_SIDE + int'(i_req.col_a)] =
                            i_req.blocked_bit;
                    end
                end else begin
                    record_expected(line_is_clear(int'(i_req.row_a), int'(i_req.col_a),
                                                  int'(i_req.row_b), int'(i_req.col_b)));
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= clear_expected.size();
    end

endmodule

// ===== bench/testbench.sv =====
module testbench import glos_pkg::*; ();

    localparam int RANDOM_ITEMS = 1825;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 140;
    localparam int LONG_HOLD    = 500;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending_checks;
    int   sent_count = 0;

    glos_req_if req_ch ();
    glos_rsp_if rsp_ch ();

    grid_line_of_sight_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    glos_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (mismatches),
        .o_pending    (pending_checks)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 63) begin
            return 6'd63;
        end
        return v[COORD_W-1:0];
    endfunction

    task automatic send_request(input logic act, input logic [COORD_W-1:0] ra,
                                input logic [COORD_W-1:0] ca, input logic [COORD_W-1:0] rb,
                                input logic [COORD_W-1:0] cb, input logic blk);
        int gap;
        gap = (sent_count % 160 < 30) ? 0 : int'($urandom_range(0, 6));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.row_a       <= ra;
        req_ch.col_a       <= ca;
        req_ch.row_b       <= rb;
        req_ch.col_b       <= cb;
        req_ch.blocked_bit <= blk;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_count++;
    endtask

    // response side: random back-pressure, two long holds, some stretches always ready
    initial begin
        int hold;
        int taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (taken == 40 || taken == 700) begin
                hold = LONG_HOLD;
            end else if (taken % 150 < 30) begin
                hold = 0;
            end else begin
                hold = int'($urandom_range(0, 6));
            end
            if (hold > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[grid_line_of_sight_check] ERROR");
        $finish;
    end

    initial begin
        int                 pick;
        logic [COORD_W-1:0] ra, ca, rb, cb;
        logic [COORD_W-1:0] hot_row, hot_col;
        logic               blk;
        hot_row = 6'd32;
        hot_col = 6'd32;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_WRITE;
        req_ch.row_a       <= '0;
        req_ch.col_a       <= '0;
        req_ch.row_b       <= '0;
        req_ch.col_b       <= '0;
        req_ch.blocked_bit <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: endpoints, directions, obstacles on either end, minor steps
        send_request(ACT_CHECK, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1);
        send_request(ACT_CHECK, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0);
        send_request(ACT_WRITE, 6'd0, 6'd0, 6'd63, 6'd63, 1'b1);
        send_request(ACT_CHECK, 6'd0, 6'd0, 6'd0, 6'd5, 1'b0);
        send_request(ACT_CHECK, 6'd0, 6'd5, 6'd0, 6'd0, 1'b0);
        send_request(ACT_WRITE, 6'd63, 6'd63, 6'd0, 6'd0, 1'b1);
        send_request(ACT_CHECK, 6'd63, 6'd0, 6'd63, 6'd63, 1'b1);
        send_request(ACT_CHECK, 6'd63, 6'd63, 6'd0, 6'd63, 1'b0);
        send_request(ACT_WRITE, 6'd10, 6'd20, 6'd0, 6'd0, 1'b1);
        send_request(ACT_CHECK, 6'd5, 6'd20, 6'd15, 6'd20, 1'b0);
        send_request(ACT_CHECK, 6'd10, 6'd10, 6'd10, 6'd30, 1'b0);
        send_request(ACT_CHECK, 6'd8, 6'd18, 6'd12, 6'd22, 1'b0);
        send_request(ACT_CHECK, 6'd12, 6'd18, 6'd8, 6'd22, 1'b0);
        send_request(ACT_CHECK, 6'd9, 6'd17, 6'd11, 6'd24, 1'b0);
        send_request(ACT_CHECK, 6'd11, 6'd24, 6'd9, 6'd17, 1'b0);
        send_request(ACT_CHECK, 6'd4, 6'd19, 6'd15, 6'd22, 1'b0);
        send_request(ACT_WRITE, 6'd10, 6'd20, 6'd0, 6'd0, 1'b0);
        send_request(ACT_CHECK, 6'd8, 6'd18, 6'd12, 6'd22, 1'b0);
        send_request(ACT_WRITE, 6'd0, 6'd63, 6'd0, 6'd0, 1'b1);
        send_request(ACT_CHECK, 6'd63, 6'd0, 6'd0, 6'd63, 1'b0);
        send_request(ACT_CHECK, 6'd0, 6'd63, 6'd63, 6'd0, 1'b0);
        send_request(ACT_WRITE, 6'd2, 6'd4, 6'd0, 6'd0, 1'b1);
        send_request(ACT_CHECK, 6'd2, 6'd3, 6'd6, 6'd7, 1'b0);
        send_request(ACT_CHECK, 6'd1, 6'd3, 6'd3, 6'd9, 1'b0);
        send_request(ACT_CHECK, 6'd3, 6'd1, 6'd9, 6'd3, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // hold off until every check has been answered
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending_checks != 0) @(posedge i_clk);
            end
            pick = int'($urandom_range(0, 9));
            ra   = COORD_W'($urandom);
            ca   = COORD_W'($urandom);
            rb   = COORD_W'($urandom);
            cb   = COORD_W'($urandom);
            if (pick < 5) begin
                blk     = ($urandom_range(0, 5) == 0);
                hot_row = ra;
                hot_col = ca;
                send_request(ACT_WRITE, ra, ca, rb, cb, blk);
            end else begin
                if (pick < 7) begin
                    rb = clamp_coord(int'(ra) + int'($urandom_range(0, 16)) - 8);
                    cb = clamp_coord(int'(ca) + int'($urandom_range(0, 16)) - 8);
                end else if (pick == 9) begin
                    // aim the line across the last written cell
                    rb = clamp_coord(2 * int'(hot_row) - int'(ra));
                    cb = clamp_coord(2 * int'(hot_col) - int'(ca));
                end
                send_request(ACT_CHECK, ra, ca, rb, cb, 1'($urandom_range(0, 1)));
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_checks != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_checks == 0) begin
            $display("[grid_line_of_sight_check] OK");
        end else begin
            $display("[grid_line_of_sight_check] ERROR");
        end
        $finish;
    end

endmodule

// ===== grid_line_of_sight_check.f =====
rtl/glos_pkg.sv
rtl/glos_req_if.sv
rtl/glos_rsp_if.sv
rtl/glos_ram.sv
rtl/glos_dp.sv
rtl/glos_ctrl.sv
rtl/grid_line_of_sight_check.sv
bench/glos_checker.sv
bench/testbench.sv
